// ===== rtl/rbi_pkg.sv =====
// Shared widths, payload types and arithmetic helpers for the ray box intersection pipeline.
`default_nettype none
package rbi_pkg;

  // Coordinate format.
  localparam int CW = 32;
  localparam int FB = 16;

  // Derived widths: direction, time numerator, cross product.
  localparam int DW = CW + 1;
  localparam int NW = CW + 2;
  localparam int PW = NW + DW;
  localparam int HS = (NW + 1) / 2;
  localparam int TS = CW / 2;
  localparam int QW = DW + CW;
  localparam int QB = CW - 1;
  localparam int SH = CW - 1 - FB;
  localparam int SW = (DW + SH > NW) ? DW + SH : NW;

  // Stream widths.
  localparam int IN_W  = ((6 * CW + 2 * (CW - 1)) + 7) / 8 * 8;
  localparam int OUT_W = ((3 * CW + 4) + 7) / 8 * 8;

  // Sign codes of a rational compare and of a face normal.
  localparam logic signed [1:0] SGN_POS  = 2'sb01;
  localparam logic signed [1:0] SGN_NEG  = 2'sb11;
  localparam logic signed [1:0] SGN_ZERO = 2'sb00;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] bl;
    logic signed [CW-1:0] bt;
    logic [CW-2:0]        bw;
    logic [CW-2:0]        bh;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] d;
    logic signed [NW-1:0] a;
    logic signed [NW-1:0] b;
  } raw_t;

  typedef struct packed {
    logic                 free;
    logic                 ok;
    logic signed [NW-1:0] nn;
    logic signed [NW-1:0] fn;
    logic [NW-1:0]        mn;
    logic [NW-1:0]        mf;
    logic [DW-1:0]        den;
    logic signed [1:0]    normal;
  } axis_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic [DW-1:0]        dxm;
    logic [DW-1:0]        dym;
    logic                 dxn;
    logic                 dyn;
  } seg_t;

  typedef struct packed {
    logic              hit;
    logic signed [1:0] nx;
    logic signed [1:0] ny;
  } flags_t;

  typedef struct packed {
    logic [NW-1:0] mag;
    logic [DW-1:0] den;
    logic          neg;
    logic          sat;
    seg_t          seg;
    flags_t        fl;
  } div_in_t;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          neg;
    logic          sat;
    seg_t          seg;
    flags_t        fl;
  } quo_t;

  typedef struct packed {
    logic              hit;
    logic signed [CW-1:0] et;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hy;
    logic signed [1:0] nx;
    logic signed [1:0] ny;
  } res_t;

  typedef struct packed {
    logic [2*HS-1:0] ll;
    logic [2*HS-1:0] lh;
    logic [2*HS-1:0] hl;
    logic [2*HS-1:0] hh;
  } pp_t;

  // Four narrow partial products of a magnitude times a denominator.
  function automatic pp_t mul_split(logic [NW-1:0] a, logic [DW-1:0] b);
    pp_t r;
    r.ll = (2*HS)'(a[HS-1:0])  * (2*HS)'(b[HS-1:0]);
    r.lh = (2*HS)'(a[HS-1:0])  * (2*HS)'(b[DW-1:HS]);
    r.hl = (2*HS)'(a[NW-1:HS]) * (2*HS)'(b[HS-1:0]);
    r.hh = (2*HS)'(a[NW-1:HS]) * (2*HS)'(b[DW-1:HS]);
    return r;
  endfunction

  function automatic logic [PW-1:0] pp_sum(pp_t p);
    return PW'(p.ll) + (PW'(p.lh) << HS) + (PW'(p.hl) << HS) + (PW'(p.hh) << (2 * HS));
  endfunction

  // Sign of n1/d1 - n2/d2 given the numerator signs and the magnitudes of the cross products.
  function automatic logic signed [1:0] rcmp(logic neg1, logic zero1, logic [PW-1:0] p1,
                                             logic neg2, logic zero2, logic [PW-1:0] p2);
    logic signed [1:0] s1;
    logic signed [1:0] s2;
    logic signed [1:0] c;
    s1 = zero1 ? SGN_ZERO : (neg1 ? SGN_NEG : SGN_POS);
    s2 = zero2 ? SGN_ZERO : (neg2 ? SGN_NEG : SGN_POS);
    c  = (p1 > p2) ? SGN_POS : ((p1 < p2) ? SGN_NEG : SGN_ZERO);
    if (s1 != s2) begin
      return (s1 > s2) ? SGN_POS : SGN_NEG;
    end
    if (s1 == SGN_ZERO) begin
      return SGN_ZERO;
    end
    return (s1 == SGN_POS) ? c : -c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rbi_slab.sv =====
// Slab setup: per-axis times, exact cross-product compares and selection of the entry time.
`default_nettype none
module rbi_slab (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire rbi_pkg::req_t    req,
  output logic                  out_vld,
  output rbi_pkg::div_in_t      out
);

  localparam int DW = rbi_pkg::DW;
  localparam int NW = rbi_pkg::NW;
  localparam int CW = rbi_pkg::CW;

  function automatic rbi_pkg::axis_t orient(rbi_pkg::raw_t r);
    rbi_pkg::axis_t x;
    logic [NW-1:0] abs_a;
    logic [NW-1:0] abs_b;
    abs_a = r.a[NW-1] ? NW'(-r.a) : NW'(r.a);
    abs_b = r.b[NW-1] ? NW'(-r.b) : NW'(r.b);
    x = '0;
    x.free = (r.d == '0);
    x.ok = 1'b1;
    if (r.d == '0) begin
      x.ok = (r.a < 0) && (r.b > 0);
    end else if (!r.d[DW-1]) begin
      x.nn = r.a;
      x.fn = r.b;
      x.mn = abs_a;
      x.mf = abs_b;
      x.den = DW'(r.d);
      x.normal = rbi_pkg::SGN_NEG;
    end else begin
      x.nn = -r.b;
      x.fn = -r.a;
      x.mn = abs_b;
      x.mf = abs_a;
      x.den = DW'(-r.d);
      x.normal = rbi_pkg::SGN_POS;
    end
    return x;
  endfunction

  // Stage 1: differences.
  logic           v1;
  rbi_pkg::raw_t  rx1, ry1;
  logic signed [CW-1:0] sx1, sy1;
  // Stage 2: oriented axes.
  logic           v2;
  rbi_pkg::axis_t ax2, ay2;
  rbi_pkg::seg_t  seg2;
  // Stage 3: partial products.
  logic           v3;
  rbi_pkg::axis_t ax3, ay3;
  rbi_pkg::seg_t  seg3;
  rbi_pkg::pp_t   pp3 [4];
  // Stage 4: cross products.
  logic           v4;
  rbi_pkg::axis_t ax4, ay4;
  rbi_pkg::seg_t  seg4;
  logic [rbi_pkg::PW-1:0] prod4 [4];

  rbi_pkg::div_in_t s5_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx1.d <= DW'(req.ex) - DW'(req.sx);
      rx1.a <= NW'(req.bl) - NW'(req.sx);
      rx1.b <= NW'(req.bl) + $signed(NW'(req.bw)) - NW'(req.sx);
      ry1.d <= DW'(req.ey) - DW'(req.sy);
      ry1.a <= NW'(req.bt) - NW'(req.sy);
      ry1.b <= NW'(req.bt) + $signed(NW'(req.bh)) - NW'(req.sy);
      sx1 <= req.sx;
      sy1 <= req.sy;

      ax2 <= orient(rx1);
      ay2 <= orient(ry1);
      seg2.sx <= sx1;
      seg2.sy <= sy1;
      seg2.dxm <= rx1.d[DW-1] ? DW'(-rx1.d) : DW'(rx1.d);
      seg2.dym <= ry1.d[DW-1] ? DW'(-ry1.d) : DW'(ry1.d);
      seg2.dxn <= rx1.d[DW-1];
      seg2.dyn <= ry1.d[DW-1];

      ax3 <= ax2;
      ay3 <= ay2;
      seg3 <= seg2;
      pp3[0] <= rbi_pkg::mul_split(ax2.mn, ay2.den);
      pp3[1] <= rbi_pkg::mul_split(ax2.mf, ay2.den);
      pp3[2] <= rbi_pkg::mul_split(ay2.mn, ax2.den);
      pp3[3] <= rbi_pkg::mul_split(ay2.mf, ax2.den);

      ax4 <= ax3;
      ay4 <= ay3;
      seg4 <= seg3;
      for (int k = 0; k < 4; k++) begin
        prod4[k] <= rbi_pkg::pp_sum(pp3[k]);
      end

      out <= s5_next;
    end
  end

  // Products: 0 = nx*dy, 1 = fx*dy, 2 = ny*dx, 3 = fy*dx.
  always_comb begin
    logic signed [1:0] c_n, c_a, c_b, c_f;
    logic cmiss;
    logic signed [NW-1:0] nn, fn;
    logic [NW-1:0] mn;
    logic [DW-1:0] den;
    logic signed [1:0] nx, ny;
    c_n = rbi_pkg::rcmp(ax4.nn < 0, ax4.nn == 0, prod4[0], ay4.nn < 0, ay4.nn == 0, prod4[2]);
    c_a = rbi_pkg::rcmp(ax4.nn < 0, ax4.nn == 0, prod4[0], ay4.fn < 0, ay4.fn == 0, prod4[3]);
    c_b = rbi_pkg::rcmp(ay4.nn < 0, ay4.nn == 0, prod4[2], ax4.fn < 0, ax4.fn == 0, prod4[1]);
    c_f = rbi_pkg::rcmp(ax4.fn < 0, ax4.fn == 0, prod4[1], ay4.fn < 0, ay4.fn == 0, prod4[3]);
    cmiss = 1'b0;
    nx = rbi_pkg::SGN_ZERO;
    ny = rbi_pkg::SGN_ZERO;
    if (ax4.free) begin
      nn = ay4.nn; mn = ay4.mn; den = ay4.den; fn = ay4.fn; ny = ay4.normal;
    end else if (ay4.free) begin
      nn = ax4.nn; mn = ax4.mn; den = ax4.den; fn = ax4.fn; nx = ax4.normal;
    end else begin
      // Disjoint intervals or an exact diagonal entry both miss.
      cmiss = (c_a >= 0) || (c_b >= 0) || (c_n == rbi_pkg::SGN_ZERO);
      if (c_n > 0) begin
        nn = ax4.nn; mn = ax4.mn; den = ax4.den; nx = ax4.normal;
      end else begin
        nn = ay4.nn; mn = ay4.mn; den = ay4.den; ny = ay4.normal;
      end
      fn = (c_f <= 0) ? ax4.fn : ay4.fn;
    end
    s5_next.mag = mn;
    s5_next.den = den;
    s5_next.neg = nn[NW-1];
    s5_next.sat = (rbi_pkg::SW'(mn) >= (rbi_pkg::SW'(den) << rbi_pkg::SH));
    s5_next.seg = seg4;
    s5_next.fl.hit = ax4.ok && ay4.ok && !(ax4.free && ay4.free) && !cmiss && (fn > 0)
                     && !(!nn[NW-1] && (mn >= NW'(den)));
    s5_next.fl.nx = nx;
    s5_next.fl.ny = ny;
  end

endmodule
`default_nettype wire

// ===== rtl/rbi_div.sv =====
// Pipelined restoring divider: one quotient bit of the entry time per stage.
`default_nettype none
module rbi_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire rbi_pkg::div_in_t din,
  output logic                  out_vld,
  output rbi_pkg::quo_t         out
);

  localparam int QB = rbi_pkg::QB;
  localparam int DW = rbi_pkg::DW;
  localparam int FB = rbi_pkg::FB;

  typedef struct packed {
    logic [DW-1:0]     rem;
    logic [QB-1:0]     q;
    rbi_pkg::div_in_t  d;
  } dst_t;

  dst_t st [QB+1];
  logic vld [QB+1];
  logic xb [QB];

  // The dividend is the numerator magnitude shifted up by the fraction bits; its high part
  // seeds the remainder, which stays below the divisor whenever the quotient does not saturate.
  always_comb begin
    st[0].rem = DW'(din.mag >> rbi_pkg::SH);
    st[0].q   = '0;
    st[0].d   = din;
    vld[0]    = in_vld;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    if (QB - 1 - k >= FB) begin : g_bit
      assign xb[k] = st[k].d.mag[QB-1-k-FB];
    end else begin : g_zero
      assign xb[k] = 1'b0;
    end

    logic [DW:0] trial;
    logic        ge;
    assign trial = {st[k].rem, xb[k]};
    assign ge = (trial >= {1'b0, st[k].d.den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].rem <= ge ? DW'(trial - {1'b0, st[k].d.den}) : DW'(trial);
        st[k+1].q   <= {st[k].q[QB-2:0], ge};
        st[k+1].d   <= st[k].d;
      end
    end
  end

  assign out_vld  = vld[QB];
  assign out.q    = st[QB].q;
  assign out.neg  = st[QB].d.neg;
  assign out.sat  = st[QB].d.sat;
  assign out.seg  = st[QB].d.seg;
  assign out.fl   = st[QB].d.fl;

endmodule
`default_nettype wire

// ===== rtl/rbi_point.sv =====
// Entry time saturation and hit point: start plus direction times entry time.
`default_nettype none
module rbi_point (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire rbi_pkg::quo_t  qin,
  output logic                out_vld,
  output rbi_pkg::res_t       out
);

  localparam int CW = rbi_pkg::CW;
  localparam int DW = rbi_pkg::DW;
  localparam int HS = rbi_pkg::HS;
  localparam int TS = rbi_pkg::TS;
  localparam int QW = rbi_pkg::QW;
  localparam int FB = rbi_pkg::FB;

  typedef struct packed {
    logic [QW-1:0] ll;
    logic [QW-1:0] lh;
    logic [QW-1:0] hl;
    logic [QW-1:0] hh;
  } ppq_t;

  function automatic ppq_t mul_pt(logic [DW-1:0] d, logic [CW-1:0] t);
    ppq_t r;
    r.ll = QW'(d[HS-1:0])  * QW'(t[TS-1:0]);
    r.lh = QW'(d[HS-1:0])  * QW'(t[CW-1:TS]);
    r.hl = QW'(d[DW-1:HS]) * QW'(t[TS-1:0]);
    r.hh = QW'(d[DW-1:HS]) * QW'(t[CW-1:TS]);
    return r;
  endfunction

  // Product shifted down by the fraction bits and clamped to twice the coordinate range.
  function automatic logic [CW+1:0] delta_mag(ppq_t p);
    logic [QW-1:0] s;
    logic [QW-1:0] big;
    s = (p.ll + (p.lh << TS) + (p.hl << HS) + (p.hh << (HS + TS))) >> FB;
    big = QW'(1) << (CW + 1);
    return (s > big) ? (CW+2)'(big) : (CW+2)'(s);
  endfunction

  function automatic logic signed [CW-1:0] place(logic signed [CW-1:0] s, logic neg,
                                                 logic [CW+1:0] m);
    logic signed [CW+2:0] p;
    p = neg ? ((CW+3)'(s) - $signed({1'b0, m})) : ((CW+3)'(s) + $signed({1'b0, m}));
    if (p[CW+2:CW-1] == '0 || p[CW+2:CW-1] == '1) begin
      return p[CW-1:0];
    end
    return p[CW+2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  logic vE, vP1, vP2;
  logic signed [CW-1:0] etE, etP1, etP2;
  logic [CW-1:0] tmagE;
  rbi_pkg::seg_t segE, segP1, segP2;
  rbi_pkg::flags_t flE, flP1, flP2;
  ppq_t ppx, ppy;
  logic [CW+1:0] dmx, dmy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vE <= 1'b0;
      vP1 <= 1'b0;
      vP2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vE <= in_vld;
      vP1 <= vE;
      vP2 <= vP1;
      out_vld <= vP2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (qin.sat) begin
        etE <= qin.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        tmagE <= qin.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        etE <= qin.neg ? -$signed(CW'(qin.q)) : $signed(CW'(qin.q));
        tmagE <= CW'(qin.q);
      end
      segE <= qin.seg;
      flE <= qin.fl;

      ppx <= mul_pt(segE.dxm, tmagE);
      ppy <= mul_pt(segE.dym, tmagE);
      etP1 <= etE;
      segP1 <= segE;
      flP1 <= flE;

      dmx <= delta_mag(ppx);
      dmy <= delta_mag(ppy);
      etP2 <= etP1;
      segP2 <= segP1;
      flP2 <= flP1;

      // A miss reports all fields as zero.
      out.hit <= flP2.hit;
      out.et <= flP2.hit ? etP2 : '0;
      out.hx <= flP2.hit ? place(segP2.sx, segP2.dxn != etP2[CW-1], dmx) : '0;
      out.hy <= flP2.hit ? place(segP2.sy, segP2.dyn != etP2[CW-1], dmy) : '0;
      out.nx <= flP2.hit ? flP2.nx : rbi_pkg::SGN_ZERO;
      out.ny <= flP2.hit ? flP2.ny : rbi_pkg::SGN_ZERO;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rbi_skid.sv =====
// Output register with a skid entry so the pipeline keeps moving while a result waits, until the skid entry fills.
`default_nettype none
module rbi_skid (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_vld,
  input  wire rbi_pkg::res_t din,
  output logic               in_ready,
  output logic               out_vld,
  input  wire logic          out_ready,
  output rbi_pkg::res_t      dout
);

  logic          skid_vld;
  rbi_pkg::res_t skid;
  logic          take;

  assign in_ready = !skid_vld;
  assign take = in_vld && !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || out_ready) begin
      if (skid_vld) begin
        out_vld <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= take;
      end
    end else if (take) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || out_ready) begin
      dout <= skid_vld ? skid : din;
    end else if (take) begin
      skid <= din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ray_box_intersect_2d.sv =====
// A result passes, in order, 5 setup stages, 31 divider stages of one quotient bit each,
// 4 hit point stages and the output register before it is presented.
// Throughput: one item per cycle while the skid entry is empty; the divider and multipliers are fully pipelined.
// The pipeline holds while the skid entry is full, so stalls lose and repeat nothing.
// Reset (rst, synchronous, active high) clears all valid bits; payload is not reset.
`default_nettype none
module ray_box_intersect_2d (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // start_x, start_y, end_x, end_y, box_left, box_top, box_width, box_height, zero pad
  input  wire logic [rbi_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // entry_time, hit_x, hit_y, normal_x, normal_y, zero pad
  output logic [rbi_pkg::OUT_W-1:0]       m_tdata,
  // hit
  output logic                            m_tuser
);

  localparam int CW = rbi_pkg::CW;

  rbi_pkg::req_t    req;
  logic             en;
  logic             v_slab, v_div, v_pt;
  rbi_pkg::div_in_t slab_out;
  rbi_pkg::quo_t    div_out;
  rbi_pkg::res_t    pt_out, res;

  assign req.sx = s_tdata[0*CW +: CW];
  assign req.sy = s_tdata[1*CW +: CW];
  assign req.ex = s_tdata[2*CW +: CW];
  assign req.ey = s_tdata[3*CW +: CW];
  assign req.bl = s_tdata[4*CW +: CW];
  assign req.bt = s_tdata[5*CW +: CW];
  assign req.bw = s_tdata[6*CW +: CW-1];
  assign req.bh = s_tdata[7*CW-1 +: CW-1];

  assign s_tready = en;

  rbi_slab u_slab (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s_tvalid), .req(req),
    .out_vld(v_slab), .out(slab_out)
  );

  rbi_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(v_slab), .din(slab_out),
    .out_vld(v_div), .out(div_out)
  );

  rbi_point u_point (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(v_div), .qin(div_out),
    .out_vld(v_pt), .out(pt_out)
  );

  rbi_skid u_skid (
    .clk(clk), .rst(rst),
    .in_vld(v_pt), .din(pt_out), .in_ready(en),
    .out_vld(m_tvalid), .out_ready(m_tready), .dout(res)
  );

  assign m_tdata = rbi_pkg::OUT_W'({res.ny, res.nx, res.hy, res.hx, res.et});
  assign m_tuser = res.hit;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the ray box intersection block, checked against a built-in slab predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int  LAT       = 40;
  localparam longint LIMIT  = 400000;
  localparam int  N_RANDOM  = 480;
  localparam int  HOLD_LEN  = 300;
  localparam longint ONE_Q  = 64'sd65536;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] et;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [1:0] nx;
    logic signed [1:0] ny;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rbi_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rbi_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;

  hit_rec_t hits_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_hits = 0;
  longint cycles = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  bit idle_ok = 1'b1;

  ray_box_intersect_2d uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Exact sign of n1/d1 - n2/d2 with positive denominators; 128-bit cross products.
  function automatic int ratio_cmp(longint n1, longint d1, longint n2, longint d2);
    logic signed [127:0] p1, p2;
    p1 = 128'(n1) * 128'(d2);
    p2 = 128'(n2) * 128'(d1);
    return (p1 > p2) ? 1 : ((p1 < p2) ? -1 : 0);
  endfunction

  function automatic longint time_fixed(longint num, longint den);
    logic signed [127:0] q;
    q = (128'(num) <<< 16) / 128'(den);  // truncates toward zero
    if (q > 128'sd2147483647) return 64'sd2147483647;
    if (q < -128'sd2147483648) return -64'sd2147483648;
    return longint'(q);
  endfunction

  function automatic longint point_at(longint s, longint d, longint t);
    logic signed [127:0] m, p;
    m = 128'(d) * 128'(t);
    m = (m < 0) ? -((-m) >>> 16) : (m >>> 16);
    p = 128'(s) + m;
    if (p > 128'sd2147483647) return 64'sd2147483647;
    if (p < -128'sd2147483648) return -64'sd2147483648;
    return longint'(p);
  endfunction

  // Per axis: returns 0 when the axis rules out a hit.
  function automatic bit slab(longint s, longint e, longint lo, longint sz, output bit free,
                              output longint nn, output longint fn, output longint den,
                              output int nrm);
    longint d, a, b;
    d = e - s; a = lo - s; b = lo + sz - s;
    free = (d == 0); nn = 0; fn = 0; den = 1; nrm = 0;
    if (free) return (a < 0) && (b > 0);
    if (d > 0) begin
      nn = a; fn = b; den = d; nrm = -1;
    end else begin
      nn = -b; fn = -a; den = -d; nrm = 1;
    end
    return 1'b1;
  endfunction

  function automatic hit_rec_t predict_hit(rbi_pkg::req_t r);
    hit_rec_t o;
    bit okx, oky, fx, fy;
    longint nnx, fnx, dnx, nny, fny, dny, nn, nd, fn, et;
    int nmx, nmy, c;
    o = '0;
    okx = slab(r.sx, r.ex, r.bl, longint'(r.bw), fx, nnx, fnx, dnx, nmx);
    oky = slab(r.sy, r.ey, r.bt, longint'(r.bh), fy, nny, fny, dny, nmy);
    if (!(okx && oky) || (fx && fy)) return o;
    if (fx) begin
      nn = nny; nd = dny; fn = fny; o.ny = 2'(nmy);
    end else if (fy) begin
      nn = nnx; nd = dnx; fn = fnx; o.nx = 2'(nmx);
    end else begin
      c = ratio_cmp(nnx, dnx, nny, dny);
      if (ratio_cmp(nnx, dnx, fny, dny) >= 0 || ratio_cmp(nny, dny, fnx, dnx) >= 0 || c == 0)
        return o;
      if (c > 0) begin
        nn = nnx; nd = dnx; o.nx = 2'(nmx);
      end else begin
        nn = nny; nd = dny; o.ny = 2'(nmy);
      end
      fn = (ratio_cmp(fnx, dnx, fny, dny) <= 0) ? fnx : fny;
    end
    if (fn <= 0 || nn >= nd) return '0;
    et = time_fixed(nn, nd);
    o.hit = 1'b1;
    o.et = 32'(et);
    o.hx = 32'(point_at(r.sx, longint'(r.ex) - longint'(r.sx), et));
    o.hy = 32'(point_at(r.sy, longint'(r.ey) - longint'(r.sy), et));
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("Mismatch on result %0d: %s got %0d expected %0d", n_got, what, got, want);
  endtask

  // Offers one item and returns at the edge where it is accepted; tvalid stays up so that
  // the next item can follow without a gap.
  task automatic send_ray(rbi_pkg::req_t r);
    logic [rbi_pkg::IN_W-1:0] w;
    w = '0;
    w[31:0] = r.sx; w[63:32] = r.sy; w[95:64] = r.ex; w[127:96] = r.ey;
    w[159:128] = r.bl; w[191:160] = r.bt; w[222:192] = r.bw; w[253:223] = r.bh;
    while (idle_ok && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    hits_due.push_back(predict_hit(r));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      m_tready <= 1'b0;
      hold_done <= hold_asks;
      hold_left <= HOLD_LEN;
    end else m_tready <= !idle_ok || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    hit_rec_t w;
    hit_rec_t g;
    if (!rst && m_tvalid && m_tready) begin
      g.hit = m_tuser;
      g.et = m_tdata[31:0];
      g.hx = m_tdata[63:32];
      g.hy = m_tdata[95:64];
      g.nx = m_tdata[97:96];
      g.ny = m_tdata[99:98];
      if (hits_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = hits_due.pop_front();
        if (g.hit !== w.hit) report_mismatch("hit", g.hit, w.hit);
        if (g.et !== w.et) report_mismatch("entry_time", g.et, w.et);
        if (g.hx !== w.hx) report_mismatch("hit_x", g.hx, w.hx);
        if (g.hy !== w.hy) report_mismatch("hit_y", g.hy, w.hy);
        if (g.nx !== w.nx) report_mismatch("normal_x", g.nx, w.nx);
        if (g.ny !== w.ny) report_mismatch("normal_y", g.ny, w.ny);
        if (w.hit) n_hits++;
      end
      n_got++;
    end
  end

  function automatic rbi_pkg::req_t make_ray(longint sx, longint sy, longint ex, longint ey,
                                             longint bl, longint bt, longint bw, longint bh);
    rbi_pkg::req_t r;
    r.sx = 32'(sx); r.sy = 32'(sy); r.ex = 32'(ex); r.ey = 32'(ey);
    r.bl = 32'(bl); r.bt = 32'(bt); r.bw = 31'(bw); r.bh = 31'(bh);
    return r;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    longint q;
    q = ONE_Q;
    send_ray(make_ray(0, 0, 10*q, 5*q, 2*q, 0, 2*q, 4*q));        // plain hit, x face
    send_ray(make_ray(0, 0, 3*q, 10*q, -q, 2*q, 5*q, 2*q));       // y face
    send_ray(make_ray(10*q, 0, 0, 1, 2*q, -q, 2*q, 2*q));         // negative direction
    send_ray(make_ray(0, 0, 4*q, 4*q, q, q, 2*q, 2*q));           // exact diagonal
    send_ray(make_ray(0, 0, 0, 10*q, -q, 2*q, 2*q, 2*q));         // zero dx, inside slab
    send_ray(make_ray(-q, 0, -q, 10*q, -q, 2*q, 2*q, 2*q));       // zero dx, on edge
    send_ray(make_ray(q, q, q, q, 0, 0, 4*q, 4*q));               // zero direction both
    send_ray(make_ray(2*q, q, 9*q, 2*q, 0, 0, 4*q, 4*q));         // start inside
    send_ray(make_ray(0, 0, q, 0, 2*q, -q, q, 2*q));              // entry beyond end
    send_ray(make_ray(9*q, 0, 20*q, 0, 2*q, -q, q, 2*q));         // exit behind start
    send_ray(make_ray(0, 0, 4*q, 3*q, 2*q, 0, 0, 4*q));           // zero width box
    send_ray(make_ray(0, 0, 4*q, 0, 2*q, -q, 2*q, 0));            // zero height box
    send_ray(make_ray(0, 0, 10*q, 10*q, 20*q, 0, q, q));          // disjoint
    send_ray(make_ray(-2147483648, -2147483648, 2147483647, 2147483647,
                      -2147483648, -2147483648, 2147483647, 2147483647));
    send_ray(make_ray(2147483647, 2147483647, -2147483648, -2147483648,
                      0, 0, 2147483647, 2147483647));
    send_ray(make_ray(-2147483648, 0, 2147483647, 1, 2147483647, -5, 0, 2147483647));
    send_ray(make_ray(0, 0, 1, 0, -2147483648, -2147483648, 2147483647, 2147483647));
    send_ray(make_ray(-2147483648, 5, -2147483647, 5, 0, 0, 2147483647, 2147483647));
    send_ray(make_ray(2147483647, -1, -1, 2147483647, -1, -1, 1, 1));
  endtask

  function automatic longint rnd_coord(int mode);
    case (mode)
      0: return longint'($signed($urandom));
      1: return longint'($signed($urandom)) >>> 12;
      default: return longint'($urandom_range(40)) * ONE_Q / 4 - 10 * ONE_Q;
    endcase
  endfunction

  task automatic test_random(int n);
    rbi_pkg::req_t r;
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(2);
      if (mode == 0) r = make_ray(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                                  rnd_coord(0), rnd_coord(0), $urandom, $urandom);
      else begin
        // Box near the segment so that most items hit or graze.
        r = make_ray(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                     rnd_coord(mode), rnd_coord(mode), 0, 0);
        r.bw = (mode == 1) ? 31'($urandom >> 12) : 31'($urandom_range(16) * ONE_Q / 2);
        r.bh = (mode == 1) ? 31'($urandom >> 12) : 31'($urandom_range(16) * ONE_Q / 2);
        if ($urandom_range(7) == 0) r.ex = r.sx;
        if ($urandom_range(7) == 0) r.ey = r.sy;
      end
      send_ray(r);
      // Long runs get a stretch with no idling on either side.
      if (n >= 200 && i == n / 2) idle_ok = 1'b0;
      if (n >= 200 && i == n / 2 + 60) idle_ok = 1'b1;
    end
  endtask

  task automatic test_backpressure();
    hold_asks++;
    test_random(80);
    wait_drained();
    repeat (20) @(posedge clk);
    test_random(20);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(N_RANDOM - 100);
    test_backpressure();
    wait_drained();
    repeat (LAT + 10) @(posedge clk);
    $display("Sent %0d rays (directed edge cases and random), %0d results, %0d hits.",
             n_sent, n_got, n_hits);
    $display("Included a long output stall and a full drain pause.");
    if (errors == 0 && hits_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
